/* rtl/core/qts_pkg.sv */
package qts_pkg;

    localparam int LENGTH_BITS = 10;
    localparam int CFG_WIDTH   = 10;

    localparam logic [31:0] MAX_RESET = 32'd255 & ((32'd1 << LENGTH_BITS) - 32'd1);

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       trunc;
    } t_result;

    // results caused by one input byte, in order
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_record;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

/* rtl/core/qts_front.sv */
module qts_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [qts_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    input  logic                           i_valid,
    input  logic [7:0]                     i_char,
    input  qts_pkg::t_queue_status         i_q_status,
    output logic                           o_ready,
    output logic                           o_push,
    output qts_pkg::t_record               o_rec
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    localparam int LB = qts_pkg::LENGTH_BITS;

    t_mode          r_mode, n_mode;
    logic           r_bs, n_bs;
    logic [LB-1:0]  r_cnt, n_cnt;
    logic           r_drop, n_drop;
    logic [LB-1:0]  r_max;

    logic [31:0]    cfg_ext;
    logic           accept;
    logic           is_ws, is_zero, in_token;
    logic           emit_a, emit_b, end_mark, ok_a, ok_b;
    logic [7:0]     byte_a;
    logic [LB-1:0]  cnt0, cnt1, cnt2;
    logic           drop0, drop1, drop2;
    qts_pkg::t_result res_a, res_b, res_e;
    qts_pkg::t_record rec;
    logic           any;

    assign cfg_ext = 32'(i_cfg_data);
    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        is_zero  = (i_char == qts_pkg::CH_NUL);
        is_ws    = (i_char == qts_pkg::CH_SPACE) || (i_char == qts_pkg::CH_TAB)
                || (i_char == qts_pkg::CH_LF) || (i_char == qts_pkg::CH_VT)
                || (i_char == qts_pkg::CH_FF) || (i_char == qts_pkg::CH_CR);
        in_token = (r_mode == MODE_PLAIN) || (r_mode == MODE_QUOTED);

        n_mode   = r_mode;
        n_bs     = r_bs;
        emit_a   = 1'b0;
        byte_a   = i_char;
        emit_b   = 1'b0;
        end_mark = 1'b0;
        cnt0     = r_cnt;
        drop0    = r_drop;

        if (!in_token) begin
            n_mode = MODE_IDLE;
            n_bs   = 1'b0;
            if (!(is_zero || is_ws)) begin
                cnt0  = '0;
                drop0 = 1'b0;
                if (i_char == qts_pkg::CH_QUOTE) begin
                    n_mode = MODE_QUOTED;
                end else begin
                    n_mode = MODE_PLAIN;
                    if (i_char == qts_pkg::CH_BACKSLASH) begin
                        n_bs = 1'b1;
                    end else begin
                        emit_a = 1'b1;
                    end
                end
            end
        end else begin
            if (r_bs && i_char == qts_pkg::CH_QUOTE) begin
                n_bs   = 1'b0;
                emit_a = 1'b1;
            end else begin
                if (r_bs) begin
                    n_bs   = 1'b0;
                    emit_a = 1'b1;
                    byte_a = qts_pkg::CH_BACKSLASH;
                end
                if (r_mode == MODE_QUOTED) begin
                    end_mark = is_zero || (i_char == qts_pkg::CH_QUOTE);
                end else begin
                    end_mark = is_zero || is_ws;
                end
                if (!end_mark) begin
                    if (i_char == qts_pkg::CH_BACKSLASH) begin
                        n_bs = 1'b1;
                    end else if (r_bs) begin
                        emit_b = 1'b1;
                    end else begin
                        emit_a = 1'b1;
                    end
                end
            end
        end

        // length limit applied to each emitted byte in turn
        ok_a  = emit_a && (cnt0 < r_max);
        cnt1  = ok_a ? cnt0 + LB'(1) : cnt0;
        drop1 = drop0 | (emit_a & !ok_a);
        ok_b  = emit_b && (cnt1 < r_max);
        cnt2  = ok_b ? cnt1 + LB'(1) : cnt1;
        drop2 = drop1 | (emit_b & !ok_b);

        if (end_mark) begin
            n_mode = MODE_IDLE;
            n_bs   = 1'b0;
            n_cnt  = '0;
            n_drop = 1'b0;
        end else begin
            n_cnt  = cnt2;
            n_drop = drop2;
        end

        res_a = '{data: byte_a, is_end: 1'b0, trunc: 1'b0};
        res_b = '{data: i_char, is_end: 1'b0, trunc: 1'b0};
        res_e = '{data: 8'h00, is_end: 1'b1, trunc: drop2};

        rec.two = 1'b0;
        rec.r0  = res_a;
        rec.r1  = res_e;
        any     = 1'b1;
        if (ok_a && ok_b) begin
            rec.two = 1'b1;
            rec.r1  = res_b;
        end else if (ok_a && end_mark) begin
            rec.two = 1'b1;
        end else if (ok_a) begin
            rec.r0 = res_a;
        end else if (ok_b) begin
            rec.r0 = res_b;
        end else if (end_mark) begin
            rec.r0 = res_e;
        end else begin
            any = 1'b0;
        end
    end

    assign o_push = accept && any;
    assign o_rec  = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_bs   <= 1'b0;
            r_cnt  <= '0;
            r_drop <= 1'b0;
            r_max  <= qts_pkg::MAX_RESET[LB-1:0];
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_bs   <= n_bs;
                r_cnt  <= n_cnt;
                r_drop <= n_drop;
            end
            if (i_cfg_valid) begin
                r_max <= cfg_ext[LB-1:0];
            end
        end
    end

endmodule

/* rtl/core/qts_queue.sv */
module qts_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  qts_pkg::t_record       i_rec,
    input  logic                   i_pop,
    output qts_pkg::t_record       o_head,
    output qts_pkg::t_queue_status o_status
);

    localparam int AW = qts_pkg::QUEUE_AW;
    localparam int DEPTH = qts_pkg::QUEUE_DEPTH;

    qts_pkg::t_record r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [AW:0]      r_count;

    assign o_status.full  = (r_count == (AW+1)'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

/* rtl/core/qts_back.sv */
module qts_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  qts_pkg::t_record       i_head,
    input  qts_pkg::t_queue_status i_q_status,
    output logic                   o_pop,
    input  logic                   i_ready,
    output logic                   o_valid,
    output qts_pkg::t_result       o_res,
    output logic                   o_last
);

    logic             r_valid;
    qts_pkg::t_result r_res;
    logic             r_last;
    logic             r_second, n_second;
    logic             load;
    qts_pkg::t_result n_res;
    logic             n_last;

    always_comb begin
        load     = (!r_valid || i_ready) && !i_q_status.empty;
        n_second = r_second;
        o_pop    = 1'b0;
        if (r_second) begin
            n_res  = i_head.r1;
            n_last = 1'b1;
        end else begin
            n_res  = i_head.r0;
            n_last = !i_head.two;
        end
        if (load) begin
            if (r_second || !i_head.two) begin
                o_pop    = 1'b1;
                n_second = 1'b0;
            end else begin
                n_second = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= n_res;
            r_last <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

endmodule

/* rtl/core/quoted_token_splitter_core.sv */
// Byte-stream tokenizer: one text byte per transfer on i_char_in, token bytes and end markers
// out, one result per transfer. A byte is taken every cycle while the two-entry result queue
// has room; a byte that yields two results (a held backslash plus the next byte or an end
// marker) is put out as two transfers, so the sustained rate is one byte per cycle unless such
// pairs or output stalls fill the queue. Results pass through the queue and an output register.
// max_token_length may only be written while no byte is in flight.
module quoted_token_splitter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qts_pkg::CFG_WIDTH-1:0]  i_cfg_max_token_length,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_char_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_is_end,
    output logic                           o_was_truncated,
    output logic                           o_last_of_item
);

    logic                   push, pop;
    qts_pkg::t_record       rec, head;
    qts_pkg::t_queue_status q_status;
    qts_pkg::t_result       res;

    assign o_cfg_ready = 1'b1;

    qts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_max_token_length),
        .i_valid    (i_valid),
        .i_char     (i_char_in),
        .i_q_status (q_status),
        .o_ready    (o_ready),
        .o_push     (push),
        .o_rec      (rec)
    );

    qts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_head  (head),
        .o_status(q_status)
    );

    qts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_status(q_status),
        .o_pop     (pop),
        .i_ready   (i_ready),
        .o_valid   (o_valid),
        .o_res     (res),
        .o_last    (o_last_of_item)
    );

    assign o_out_byte      = res.data;
    assign o_is_end        = res.is_end;
    assign o_was_truncated = res.trunc;

endmodule

/* tb/quoted_token_splitter_core_tb.sv */
`timescale 1ns / 1ps

module quoted_token_splitter_core_tb;
    import qts_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE_TICKS = 8;
    localparam int unsigned PHASE_ITEMS  = 100;

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_PLAIN  = 2'd1,
        SCAN_QUOTED = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       trunc;
        logic       last;
    } token_out_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_WIDTH-1:0] i_cfg_max_token_length;
    logic                 i_valid;
    logic                 o_ready;
    logic [7:0]           i_char_in;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_is_end;
    logic                 o_was_truncated;
    logic                 o_last_of_item;

    token_out_t token_q[$];
    token_out_t step_q[$];

    scan_mode_t           scan_mode;
    logic                 held_backslash;
    logic [LENGTH_BITS-1:0] tok_count;
    logic                 tok_dropped;
    logic [LENGTH_BITS-1:0] max_len;

    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned token_items = 0;

    quoted_token_splitter_core DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_max_token_length (i_cfg_max_token_length),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_char_in              (i_char_in),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_out_byte             (o_out_byte),
        .o_is_end               (o_is_end),
        .o_was_truncated        (o_was_truncated),
        .o_last_of_item         (o_last_of_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_ws(logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic void emit_tok_byte(logic [7:0] b);
        token_out_t r;
        if (tok_count < max_len) begin
            r = '0;
            r.data = b;
            step_q.push_back(r);
            tok_count = tok_count + LENGTH_BITS'(1);
        end else begin
            tok_dropped = 1'b1;
        end
    endfunction

    function automatic void close_token();
        token_out_t r;
        r = '0;
        r.is_end = 1'b1;
        r.trunc  = tok_dropped;
        step_q.push_back(r);
        scan_mode      = SCAN_IDLE;
        held_backslash = 1'b0;
        tok_count      = '0;
        tok_dropped    = 1'b0;
    endfunction

    function automatic void predict_char(logic [7:0] c);
        bit in_quotes;
        bit escaped;
        bit ends;
        step_q.delete();
        if (scan_mode != SCAN_PLAIN && scan_mode != SCAN_QUOTED) begin
            scan_mode      = SCAN_IDLE;
            held_backslash = 1'b0;
            if (c != CH_NUL && !is_ws(c)) begin
                tok_count   = '0;
                tok_dropped = 1'b0;
                if (c == CH_QUOTE) begin
                    scan_mode = SCAN_QUOTED;
                end else begin
                    scan_mode = SCAN_PLAIN;
                    if (c == CH_BACKSLASH) held_backslash = 1'b1;
                    else emit_tok_byte(c);
                end
            end
        end else begin
            in_quotes = (scan_mode == SCAN_QUOTED);
            escaped   = 1'b0;
            if (held_backslash) begin
                held_backslash = 1'b0;
                if (c == CH_QUOTE) begin
                    emit_tok_byte(c);
                    escaped = 1'b1;
                end else begin
                    emit_tok_byte(CH_BACKSLASH);
                end
            end
            if (!escaped) begin
                ends = in_quotes ? (c == CH_NUL || c == CH_QUOTE) : (c == CH_NUL || is_ws(c));
                if (ends) close_token();
                else if (c == CH_BACKSLASH) held_backslash = 1'b1;
                else emit_tok_byte(c);
            end
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i]) token_q.push_back(step_q[i]);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (is_ws(c) || c == CH_QUOTE || c == CH_BACKSLASH);
        return c;
    endfunction

    function automatic logic [7:0] body_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 8'($urandom_range(8'h21, 8'h7E));
        if (r < 75) return CH_BACKSLASH;
        if (r < 88) return CH_QUOTE;
        if (r < 94) return CH_SPACE;
        return 8'($urandom_range(1, 255));
    endfunction

    // entered and left at a falling edge
    task automatic send_char(input logic [7:0] c);
        while (src_idle_en && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_char(c);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(8'(s[i]));
    endtask

    task automatic wait_idle();
        while (token_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic write_max_len(input logic [LENGTH_BITS-1:0] v);
        i_valid <= 1'b0;
        wait_idle();
        i_cfg_valid            <= 1'b1;
        i_cfg_max_token_length <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        max_len = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic long_token(input int unsigned n);
        repeat (n) send_char(plain_char());
        send_char(CH_SPACE);
    endtask

    task automatic send_random_token();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(99);
        if (r < 45) begin
            n = ($urandom_range(99) < 10) ? $urandom_range(1, 40) : $urandom_range(1, 10);
            repeat (n) send_char(body_char());
            token_items += n;
        end else if (r < 85) begin
            n = $urandom_range(0, 12);
            send_char(CH_QUOTE);
            repeat (n) send_char(body_char());
            token_items += n + 1;
            if ($urandom_range(99) < 90) begin
                send_char(CH_QUOTE);
                token_items++;
            end
        end else if (r < 93) begin
            n = $urandom_range(1, 4);
            repeat (n) send_char(8'($urandom_range(255)));
            token_items += n;
        end else begin
            send_char(CH_NUL);
            token_items++;
        end
        if ($urandom_range(99) < 90) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                case ($urandom_range(5))
                    0: send_char(CH_SPACE);
                    1: send_char(CH_TAB);
                    2: send_char(CH_LF);
                    3: send_char(CH_VT);
                    4: send_char(CH_FF);
                    default: send_char(CH_CR);
                endcase
            end
            token_items += n;
        end
    endtask

    task automatic test_directed_tokens();
        send_char(CH_NUL);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(CH_TAB);
        // quoted with inner space, escaped quote, backslash pair whose second backslash escapes a quote
        send_text("\"a \\\"\\\\\"\"");
        send_char(CH_LF);
        send_text("\"\"");
        // quote inside plain token, held backslash before a plain byte
        send_text("q\"\\z");
        send_char(CH_VT);
        send_char(CH_BACKSLASH);
        send_char(CH_FF);
        send_text("w");
        send_char(CH_NUL);
        send_char(CH_CR);
        send_char(CH_SPACE);
        send_char(8'h01);
        send_char(8'h7F);
        send_char(CH_NUL);
    endtask

    task automatic test_length_limits();
        write_max_len('0);
        send_text("ab ");
        send_text("\"\" ");
        send_char(CH_BACKSLASH);
        send_char(CH_SPACE);
        write_max_len(10'd1);
        send_text("ab ");
        send_text("\"x\" ");
        write_max_len(10'd1023);
        long_token(1024);
    endtask

    task automatic test_random_stream();
        logic [LENGTH_BITS-1:0] limits [8];
        bit paused;
        limits = '{10'd3, 10'd0, 10'd1023, 10'd7, 10'd1, 10'd255, 10'd2, 10'd0};
        limits[7] = 10'($urandom_range(1023));
        paused = 1'b0;
        for (int p = 0; p < 8; p++) begin
            write_max_len(limits[p]);
            src_idle_en  = (p != 5);
            sink_idle_en = (p != 5);
            token_items  = 0;
            while (token_items < PHASE_ITEMS) begin
                send_random_token();
                if (p == 2 && !paused && token_items >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    i_valid <= 1'b0;
                    do @(negedge i_clk); while (token_q.size() != 0);
                end
            end
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    always @(negedge i_clk) begin
        i_ready <= !sink_idle_en || ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        token_out_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (token_q.size() == 0) begin
                $error("unexpected transfer: out_byte %0h is_end %0b", o_out_byte, o_is_end);
                mismatch_count++;
            end else begin
                want = token_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %0h, actual %0h", want.data, o_out_byte);
                    mismatch_count++;
                end
                if (o_is_end !== want.is_end) begin
                    $error("is_end: expected %0b, actual %0b", want.is_end, o_is_end);
                    mismatch_count++;
                end
                if (o_was_truncated !== want.trunc) begin
                    $error("was_truncated: expected %0b, actual %0b", want.trunc,
                           o_was_truncated);
                    mismatch_count++;
                end
                if (o_last_of_item !== want.last) begin
                    $error("last_of_item: expected %0b, actual %0b", want.last,
                           o_last_of_item);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n                = 1'b0;
        i_valid                = 1'b0;
        i_char_in              = '0;
        i_cfg_valid            = 1'b0;
        i_cfg_max_token_length = '0;
        scan_mode              = SCAN_IDLE;
        held_backslash         = 1'b0;
        tok_count              = '0;
        tok_dropped            = 1'b0;
        max_len                = LENGTH_BITS'(MAX_RESET);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_tokens();
        test_length_limits();
        test_random_stream();

        i_valid <= 1'b0;
        wait_idle();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* quoted_token_splitter_core.f */
rtl/core/qts_pkg.sv
rtl/core/qts_front.sv
rtl/core/qts_queue.sv
rtl/core/qts_back.sv
rtl/core/quoted_token_splitter_core.sv
tb/quoted_token_splitter_core_tb.sv
